// ===== hw/rtl/ipfa_pkg.sv =====
// ipfa_pkg: shared types and helpers for the ipv4 prefix acl filter
// no dependencies; imported by ipfa_cell and ipv4_prefix_acl_filter
`timescale 1ns / 1ps
`default_nettype none

package ipfa_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned LenW  = 6;
  localparam logic [LenW-1:0] MaxLen = LenW'(AddrW);

  typedef enum logic [1:0] {
    CMD_CHECK   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_PREPEND = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [AddrW-1:0] address;
    logic [LenW-1:0]  prefix_len;
    logic             accept_mark;
  } in_word_t;

  typedef struct packed {
    logic decision;
    logic rule_hit;
    logic status;
  } out_word_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [LenW-1:0]  len;
    logic             mark;
  } rule_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic             decision;
    logic [AddrW-1:0] addr;
  } token_t;

  typedef struct packed {
    logic append;
    logic prepend;
  } cell_ctl_t;

  // top len bits set; len is at most 32
  function automatic logic [AddrW-1:0] prefix_mask(input logic [LenW-1:0] len);
    prefix_mask = ~({AddrW{1'b1}} >> len);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ipfa_cell.sv =====
// ipfa_cell: one rule slot of the acl chain plus one stage of the lookup token
// depends on ipfa_pkg
`timescale 1ns / 1ps
`default_nettype none

module ipfa_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 6
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ipfa_pkg::cell_ctl_t ctl_i,
  input  wire  [CNT_W-1:0]    count_i,
  input  ipfa_pkg::rule_t     new_rule_i,
  input  ipfa_pkg::rule_t     prev_rule_i,
  output ipfa_pkg::rule_t     rule_o,
  input  ipfa_pkg::token_t    tok_i,
  output ipfa_pkg::token_t    tok_o
);
  import ipfa_pkg::*;

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  rule_t  rule_q, rule_d;
  token_t tok_q, tok_d;
  logic   active, match;

  assign active = MyIdx < count_i;
  assign match  = active &&
                  (((tok_i.addr ^ rule_q.addr) & prefix_mask(rule_q.len)) == '0);

  always_comb begin
    rule_d = rule_q;
    if (ctl_i.prepend) begin
      rule_d = prev_rule_i;
    end else if (ctl_i.append && (count_i == MyIdx)) begin
      rule_d = new_rule_i;
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (!tok_i.found && match) begin
      tok_d.found    = 1'b1;
      tok_d.decision = rule_q.mark;
    end
  end

  always_ff @(posedge clk_i) begin
    rule_q <= rule_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign rule_o = rule_q;
  assign tok_o  = tok_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ipv4_prefix_acl_filter.sv =====
// ipv4_prefix_acl_filter: first-match ipv4 prefix acl built as a row of rule cells
// depends on ipfa_pkg and ipfa_cell
//
//   channel   signals                          direction  accepted when
//   command   start, busy, cmd_i               in         start & !busy
//   result    done_o, result_o                 out        done_o (one cycle, no stall)
//   config    cfg_valid_i, cfg_ready_o, cfg_data_i  in    cfg_valid_i & cfg_ready_o
//
// append, prepend and clear give their result in the cycle after acceptance
// and the next word can be taken in that cycle.
// a check walks one cell per cycle down the chain, so its result shows
// when its token leaves the last cell; busy stays high until that result cycle.
// reset clears the rule count, the default and the token valids; rule
// contents stay undefined until written. results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_prefix_acl_filter #(
  parameter int unsigned RULE_SLOTS = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  input  ipfa_pkg::in_word_t   cmd_i,
  output logic                 done_o,
  output ipfa_pkg::out_word_t  result_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire                  cfg_data_i
);
  import ipfa_pkg::*;

  localparam int unsigned CntW = $clog2(RULE_SLOTS + 1);
  localparam logic [CntW-1:0] Full = CntW'(RULE_SLOTS);

  logic [CntW-1:0] count_q, count_d;
  logic            dflt_q;
  logic            busy_q, busy_d;
  logic            misc_valid_q, misc_valid_d;
  out_word_t       misc_q, misc_d;
  logic            accept, is_full, is_insert;
  cmd_e            cmd;
  cell_ctl_t       ctl;
  rule_t           new_rule;
  token_t          inj_tok;
  rule_t           rule_chain [RULE_SLOTS];
  token_t          tok_chain  [RULE_SLOTS];
  token_t          last_tok;

  assign cmd       = cmd_e'(cmd_i.command);
  assign last_tok  = tok_chain[RULE_SLOTS-1];
  assign busy      = busy_q && !last_tok.valid;
  assign accept    = start && !busy;
  assign is_full   = count_q == Full;
  assign is_insert = (cmd == CMD_APPEND) || (cmd == CMD_PREPEND);
  assign cfg_ready_o = 1'b1;

  assign new_rule.addr = cmd_i.address;
  assign new_rule.len  = (cmd_i.prefix_len > MaxLen) ? MaxLen : cmd_i.prefix_len;
  assign new_rule.mark = cmd_i.accept_mark;

  assign ctl.append  = accept && (cmd == CMD_APPEND) && !is_full;
  assign ctl.prepend = accept && (cmd == CMD_PREPEND) && !is_full;

  assign inj_tok.valid    = accept && (cmd == CMD_CHECK);
  assign inj_tok.found    = 1'b0;
  assign inj_tok.decision = dflt_q;
  assign inj_tok.addr     = cmd_i.address;

  always_comb begin
    count_d      = count_q;
    busy_d       = busy_q;
    misc_valid_d = 1'b0;
    misc_d       = '0;
    if (last_tok.valid) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      unique case (cmd)
        CMD_CHECK: begin
          busy_d = 1'b1;
        end
        CMD_APPEND, CMD_PREPEND: begin
          misc_valid_d = 1'b1;
          misc_d.status = is_full;
          if (!is_full) begin
            count_d = count_q + CntW'(1);
          end
        end
        CMD_CLEAR: begin
          misc_valid_d = 1'b1;
          count_d = '0;
        end
        default: begin
          busy_d = busy_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      dflt_q       <= 1'b0;
      busy_q       <= 1'b0;
      misc_valid_q <= 1'b0;
    end else begin
      count_q      <= count_d;
      busy_q       <= busy_d;
      misc_valid_q <= misc_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        dflt_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    misc_q <= misc_d;
  end

  for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
    rule_t  prev_rule;
    token_t prev_tok;
    if (g == 0) begin : g_head
      assign prev_rule = new_rule;
      assign prev_tok  = inj_tok;
    end else begin : g_body
      assign prev_rule = rule_chain[g-1];
      assign prev_tok  = tok_chain[g-1];
    end
    ipfa_cell #(
      .IDX   (g),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .count_i     (count_q),
      .new_rule_i  (new_rule),
      .prev_rule_i (prev_rule),
      .rule_o      (rule_chain[g]),
      .tok_i       (prev_tok),
      .tok_o       (tok_chain[g])
    );
  end

  assign done_o = misc_valid_q || last_tok.valid;

  always_comb begin
    result_o = misc_q;
    if (last_tok.valid) begin
      result_o.decision = last_tok.decision;
      result_o.rule_hit = last_tok.found;
      result_o.status   = 1'b0;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("rule count above table size");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_insert && is_full) |=> (done_o && result_o.status && $stable(count_q)))
    else $error("insert into full table not refused");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(misc_valid_q && last_tok.valid))
    else $error("check and command results collide");

  a_hit_only_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && misc_valid_q) |-> (!result_o.rule_hit && !result_o.decision))
    else $error("non-check result carries a decision");
`endif

endmodule

`default_nettype wire

// ===== dv/ipv4_prefix_acl_filter_checker.sv =====
// ipv4_prefix_acl_filter_checker: watches the command, result and config channels
// keeps its own rule table and default, predicts each verdict and compares it
// depends on ipfa_pkg for the word types and command codes
`timescale 1ns / 1ps

module ipv4_prefix_acl_filter_checker #(
  parameter int unsigned RULE_SLOTS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  ipfa_pkg::in_word_t  cmd_i,
  input  logic                done_i,
  input  ipfa_pkg::out_word_t result_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_data_i,
  output int                  failures_o,
  output int                  outstanding_o
);

  import ipfa_pkg::*;

  rule_t     rules [RULE_SLOTS];
  int        rule_count;
  logic      default_accept;
  out_word_t verdict_q[$];

  function automatic logic [AddrW-1:0] len_mask(input logic [LenW-1:0] n);
    if (n == '0) return '0;
    return {AddrW{1'b1}} << (AddrW - int'(n));
  endfunction

  // updates the table as the block would and returns the verdict word
  function automatic out_word_t apply_command(input in_word_t w);
    out_word_t        r;
    rule_t            fresh;
    logic [AddrW-1:0] m;
    r = '0;
    fresh.addr = w.address;
    fresh.len  = (w.prefix_len > MaxLen) ? MaxLen : w.prefix_len;
    fresh.mark = w.accept_mark;
    case (w.command)
      CMD_CHECK: begin
        r.decision = default_accept;
        for (int i = 0; i < rule_count && !r.rule_hit; i++) begin
          m = len_mask(rules[i].len);
          if ((w.address & m) == (rules[i].addr & m)) begin
            r.decision = rules[i].mark;
            r.rule_hit = 1'b1;
          end
        end
      end
      CMD_APPEND, CMD_PREPEND: begin
        if (rule_count >= RULE_SLOTS) begin
          r.status = 1'b1;
        end else if (w.command == CMD_PREPEND) begin
          for (int i = rule_count; i > 0; i--) rules[i] = rules[i - 1];
          rules[0] = fresh;
          rule_count++;
        end else begin
          rules[rule_count] = fresh;
          rule_count++;
        end
      end
      default: begin
        rule_count = 0;
      end
    endcase
    return r;
  endfunction

  task automatic flag(input string field, input logic want, input logic got);
    if (got !== want) begin
      if (failures_o < 100) $error("%s: expected %0b, actual %0b", field, want, got);
      failures_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      rule_count     = 0;
      default_accept = 1'b0;
      verdict_q.delete();
      outstanding_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) default_accept = cfg_data_i;
      if (done_i) begin
        if (verdict_q.size() == 0) begin
          if (failures_o < 100) begin
            $error("result: word with nothing waiting, decision %0b rule_hit %0b status %0b",
                   result_i.decision, result_i.rule_hit, result_i.status);
          end
          failures_o++;
        end else begin
          want = verdict_q.pop_front();
          flag("decision", want.decision, result_i.decision);
          flag("rule_hit", want.rule_hit, result_i.rule_hit);
          flag("status", want.status, result_i.status);
        end
      end
      if (start_i && !busy_i) verdict_q.push_back(apply_command(cmd_i));
      outstanding_o = verdict_q.size();
    end
  end

endmodule

// ===== dv/ipv4_prefix_acl_filter_test.sv =====
// ipv4_prefix_acl_filter_test: clock, reset and command stimulus for the acl filter
// directed rules and checks, then random phases with changing default and idle gaps
// depends on ipfa_pkg, ipv4_prefix_acl_filter and ipv4_prefix_acl_filter_checker
`timescale 1ns / 1ps

module ipv4_prefix_acl_filter_test;

  import ipfa_pkg::*;

  localparam int unsigned RuleSlots  = 32;
  localparam int          TotalItems = 1375;
  localparam int          CycleLimit = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  cmd = '0;
  logic      done;
  out_word_t result;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;
  int        failures;
  int        outstanding;
  int        sent;
  int        cycle_count;
  rule_t     known_rules[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ipv4_prefix_acl_filter #(
    .RULE_SLOTS(RuleSlots)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd),
    .done_o     (done),
    .result_o   (result),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  ipv4_prefix_acl_filter_checker #(
    .RULE_SLOTS(RuleSlots)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd),
    .done_i       (done),
    .result_i     (result),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .failures_o   (failures),
    .outstanding_o(outstanding)
  );

  function automatic in_word_t mk(input cmd_e c, input logic [AddrW-1:0] a,
                                  input logic [LenW-1:0] n, input logic k);
    in_word_t w;
    w.command     = c;
    w.address     = a;
    w.prefix_len  = n;
    w.accept_mark = k;
    return w;
  endfunction

  // mode 0 fills the table, 1 balanced, 2 mostly checks, 3 raw noise
  function automatic in_word_t random_word(input int mode);
    in_word_t         w;
    rule_t            r;
    rule_t            kept;
    logic [AddrW-1:0] m;
    int               pick;
    int               clear_pct;
    int               insert_pct;
    int               len_pick;
    w.command     = 2'($urandom_range(0, 3));
    w.address     = $urandom;
    w.prefix_len  = 6'($urandom_range(0, 63));
    w.accept_mark = 1'($urandom_range(0, 1));
    if (mode != 3) begin
      clear_pct  = (mode == 0) ? 0 : ((mode == 1) ? 3 : 2);
      insert_pct = (mode == 0) ? 85 : ((mode == 1) ? 45 : 15);
      pick = $urandom_range(0, 99);
      if (pick < clear_pct) begin
        w.command = CMD_CLEAR;
      end else if (pick < clear_pct + insert_pct) begin
        w.command = $urandom_range(0, 1) ? CMD_APPEND : CMD_PREPEND;
        len_pick = $urandom_range(0, 19);
        if (len_pick < 14) begin
          w.prefix_len = 6'($urandom_range(0, 32));
        end else if (len_pick < 17) begin
          w.prefix_len = 6'($urandom_range(33, 63));
        end else begin
          case ($urandom_range(0, 5))
            0: w.prefix_len = 6'd0;
            1: w.prefix_len = 6'd1;
            2: w.prefix_len = 6'd31;
            3: w.prefix_len = 6'd32;
            4: w.prefix_len = 6'd33;
            default: w.prefix_len = 6'd63;
          endcase
        end
        if (known_rules.size() > 0 && $urandom_range(0, 9) < 3) begin
          r = known_rules[$urandom_range(0, known_rules.size() - 1)];
          w.address = r.addr ^ ($urandom >> $urandom_range(0, 31));
        end
      end else begin
        w.command = CMD_CHECK;
        if (known_rules.size() > 0 && $urandom_range(0, 3) != 0) begin
          r = known_rules[$urandom_range(0, known_rules.size() - 1)];
          m = (r.len == '0) ? '0 : ({AddrW{1'b1}} << (AddrW - int'(r.len)));
          w.address = (r.addr & m) | ($urandom & ~m);
          // near miss on the last prefix bit
          if (r.len != '0 && $urandom_range(0, 3) == 0) begin
            w.address = w.address ^ (32'h1 << (AddrW - int'(r.len)));
          end
        end
      end
    end
    case (w.command)
      CMD_CLEAR: known_rules.delete();
      CMD_APPEND, CMD_PREPEND: begin
        if (known_rules.size() < RuleSlots) begin
          kept.addr = w.address;
          kept.len  = (w.prefix_len > MaxLen) ? MaxLen : w.prefix_len;
          kept.mark = w.accept_mark;
          known_rules.push_back(kept);
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input bit idle_ok);
    int gap;
    gap = idle_ok ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= w;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_default(input logic v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int   phase;
    int   mode;
    int   span;
    bit   idle_ok;
    logic dflt;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_default(1'b0);
    send_word(mk(CMD_CHECK, 32'h0000_0000, 6'd0, 1'b0), 1'b1);
    send_word(mk(CMD_CHECK, 32'hFFFF_FFFF, 6'd63, 1'b1), 1'b1);
    send_word(mk(CMD_APPEND, 32'h0A00_0000, 6'd8, 1'b1), 1'b1);
    send_word(mk(CMD_APPEND, 32'hC0A8_0180, 6'd25, 1'b0), 1'b1);
    send_word(mk(CMD_CHECK, 32'h0AFF_FFFF, 6'd0, 1'b0), 1'b1);
    send_word(mk(CMD_CHECK, 32'h0B00_0000, 6'd0, 1'b0), 1'b1);
    send_word(mk(CMD_CHECK, 32'hC0A8_0181, 6'd0, 1'b0), 1'b1);
    send_word(mk(CMD_CHECK, 32'hC0A8_017F, 6'd0, 1'b0), 1'b1);
    send_word(mk(CMD_PREPEND, 32'h0A01_0000, 6'd16, 1'b0), 1'b1);
    send_word(mk(CMD_CHECK, 32'h0A01_0203, 6'd0, 1'b0), 1'b1);
    // overlong prefix lengths get saturated
    send_word(mk(CMD_APPEND, 32'hFFFF_FFFF, 6'd63, 1'b1), 1'b1);
    send_word(mk(CMD_CHECK, 32'hFFFF_FFFF, 6'd0, 1'b0), 1'b1);
    send_word(mk(CMD_CHECK, 32'hFFFF_FFFE, 6'd0, 1'b0), 1'b1);
    // zero length rule matches everything
    send_word(mk(CMD_APPEND, 32'h0000_0000, 6'd0, 1'b1), 1'b1);
    send_word(mk(CMD_CHECK, 32'h1234_5678, 6'd0, 1'b0), 1'b1);
    send_word(mk(CMD_APPEND, 32'h5555_5555, 6'd33, 1'b0), 1'b1);
    send_word(mk(CMD_PREPEND, 32'h8000_0000, 6'd1, 1'b0), 1'b1);
    send_word(mk(CMD_CHECK, 32'h7FFF_FFFF, 6'd0, 1'b0), 1'b1);
    send_word(mk(CMD_CHECK, 32'h8000_0000, 6'd0, 1'b0), 1'b1);
    send_word(mk(CMD_CLEAR, 32'hFFFF_FFFF, 6'd63, 1'b1), 1'b1);
    send_word(mk(CMD_CHECK, 32'hFFFF_FFFF, 6'd0, 1'b0), 1'b1);
    write_default(1'b1);
    send_word(mk(CMD_CHECK, 32'h0000_0000, 6'd0, 1'b0), 1'b1);

    phase = 0;
    while (sent < TotalItems) begin
      dflt = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
      write_default(dflt);
      case ($urandom_range(0, 9))
        0, 1, 2: mode = 0;
        3, 4, 5: mode = 1;
        6, 7, 8: mode = 2;
        default: mode = 3;
      endcase
      if (phase == 0) mode = 0;
      idle_ok = ($urandom_range(0, 2) != 0);
      span = $urandom_range(20, 60);
      repeat (span) send_word(random_word(mode), idle_ok);
      phase++;
    end

    drain_results();
    repeat (RuleSlots + 4) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
